// ===== rtl/ple_pkg.sv =====
// Shared types and constants for the positional list engine.
// No dependencies; used by the top level, the checker and the testbench.
`timescale 1ns / 1ps
package ple_pkg;

  localparam int unsigned ReqW  = 3;
  localparam int unsigned DataW = 32;
  localparam int unsigned PosW  = 6;
  localparam int unsigned InW   = ReqW + DataW + 2 * PosW + DataW;
  localparam int unsigned InPadW = ((InW + 7) / 8) * 8;

  typedef enum logic [ReqW-1:0] {
    REQ_INSERT = 3'd0,
    REQ_REMOVE = 3'd1,
    REQ_PRINT  = 3'd2,
    REQ_MOVE   = 3'd3,
    REQ_REVERSE = 3'd4,
    REQ_ROT_L  = 3'd5,
    REQ_ROT_R  = 3'd6,
    REQ_NONE   = 3'd7
  } req_t;

  // reversal passes used to build a rotation out of three reversals
  typedef enum logic [1:0] {
    PASS_ALL  = 2'd0,
    PASS_HEAD = 2'd1,
    PASS_TAIL = 2'd2
  } pass_t;

endpackage

// ===== rtl/ple_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
module ple_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/positional_list_engine_unit.sv =====
// Positional list engine top level: request sequencer around one element RAM.
// Depends on ple_pkg and ple_ram.
`timescale 1ns / 1ps
// Usage:
//   Requests arrive on the in_ stream, one transfer per request. The block
//   takes a request only while its sequencer is idle, then works on it alone.
//   Print requests produce results on the out_ stream: one transfer per list
//   value in order, out_tlast on the final one; an empty list gives a single
//   transfer with data 0, tlast 1 and out_tuser (empty flag) 1.
//   Insert shifts the elements from position p upward up one place, remove
//   shifts those above p down, move is a remove then an insert, reverse swaps
//   pairs from both ends, rotate runs a remainder divider and then three
//   reversals, and print reads each value before it is sent.
//   The RAM has one read and one write port; every element move is a read
//   followed by a write.
//   The result register frees the sequencer: a new request is accepted while
//   a finished result still waits. A stalled receiver holds a print at its
//   current value. Reset empties the list; no clearing pass is needed.
module positional_list_engine_unit #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // req_type[2:0], data_in[34:3], pos_a[40:35], pos_b[46:41],
  // shift_amount[78:47], zero pad [79]
  input  logic [ple_pkg::InPadW-1:0] in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // data_out[31:0]
  output logic [ple_pkg::DataW-1:0] out_tdata,
  output logic                     out_tlast,
  // list_empty[0]
  output logic                     out_tuser
);

  import ple_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > PosW) ? CW : PosW;
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_INS    = 14'b00000000000010,
    S_INS_WR = 14'b00000000000100,
    S_REM    = 14'b00000000001000,
    S_REM_WR = 14'b00000000010000,
    S_MV_CAP = 14'b00000000100000,
    S_DIV    = 14'b00000001000000,
    S_RV_CHK = 14'b00000010000000,
    S_RV_RDB = 14'b00000100000000,
    S_RV_WA  = 14'b00001000000000,
    S_RV_WB  = 14'b00010000000000,
    S_PR_RD  = 14'b00100000000000,
    S_PR_LD  = 14'b01000000000000,
    S_PR_EMP = 14'b10000000000000
  } state_t;

  // input unpacking
  logic [ReqW-1:0]  in_req;
  logic [DataW-1:0] in_data;
  logic [PosW-1:0]  in_pa, in_pb;
  logic [DataW-1:0] in_shift;
  assign in_req   = in_tdata[ReqW-1:0];
  assign in_data  = in_tdata[ReqW+DataW-1:ReqW];
  assign in_pa    = in_tdata[ReqW+DataW+PosW-1:ReqW+DataW];
  assign in_pb    = in_tdata[ReqW+DataW+2*PosW-1:ReqW+DataW+PosW];
  assign in_shift = in_tdata[InW-1:ReqW+DataW+2*PosW];

  // registers
  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;     // sweep index
  logic [CW-1:0]    pos_r, pos_nxt;     // insert target
  logic [DataW-1:0] val_r, val_nxt;     // value to insert / swap temp
  logic [PosW-1:0]  pb_r, pb_nxt;
  logic             mv_r, mv_nxt;
  logic [CW-1:0]    lo_r, lo_nxt, hi_r, hi_nxt;
  pass_t            pass_r, pass_nxt;
  logic [CW-1:0]    k_r, k_nxt;
  logic [DataW-1:0] mag_r, mag_nxt;
  logic [CW-1:0]    rem_r, rem_nxt;
  logic [4:0]       bit_r, bit_nxt;
  logic             neg_r, neg_nxt;
  logic             ovld_r, ovld_nxt;
  logic [DataW-1:0] odata_r, odata_nxt;
  logic             olast_r, olast_nxt;
  logic             oempty_r, oempty_nxt;

  // RAM ports
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [DataW-1:0] ram_wdata, ram_rdata;

  ple_ram #(.WIDTH(DataW), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic in_xfer, out_free;
  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_free   = !ovld_r || out_tready;
  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = oempty_r;

  // divider step and rotation amount
  logic [CW:0]   div_cur;
  logic [CW:0]   div_sub;
  logic [CW-1:0] rem_step;
  logic [CW-1:0] k_calc;
  always_comb begin
    div_cur  = {rem_r, mag_r[DataW-1]};
    div_sub  = div_cur - {1'b0, count_r};
    rem_step = (div_cur >= {1'b0, count_r}) ? div_sub[CW-1:0] : div_cur[CW-1:0];
    k_calc   = (neg_r && rem_r != '0) ? (count_r - rem_r) : rem_r;
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    pb_nxt     = pb_r;
    mv_nxt     = mv_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    pass_nxt   = pass_r;
    k_nxt      = k_r;
    mag_nxt    = mag_r;
    rem_nxt    = rem_r;
    bit_nxt    = bit_r;
    neg_nxt    = neg_r;
    ovld_nxt   = ovld_r && !out_tready;
    odata_nxt  = odata_r;
    olast_nxt  = olast_r;
    oempty_nxt = oempty_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = idx_r[AW-1:0];
    ram_raddr  = idx_r[AW-1:0];
    ram_wdata  = ram_rdata;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          pb_nxt = in_pb;
          mv_nxt = 1'b0;
          case (in_req)
            REQ_INSERT: begin
              if (count_r < CapC) begin
                val_nxt   = in_data;
                idx_nxt   = count_r;
                pos_nxt   = (XW'(in_pa) > XW'(count_r)) ? count_r : CW'(in_pa);
                state_nxt = S_INS;
              end
            end
            REQ_REMOVE: begin
              if (XW'(in_pa) < XW'(count_r)) begin
                idx_nxt   = CW'(in_pa);
                state_nxt = S_REM;
              end
            end
            REQ_MOVE: begin
              if (in_pa != in_pb && XW'(in_pa) < XW'(count_r)) begin
                ram_re    = 1'b1;
                ram_raddr = AW'(in_pa);
                idx_nxt   = CW'(in_pa);
                mv_nxt    = 1'b1;
                state_nxt = S_MV_CAP;
              end
            end
            REQ_PRINT: begin
              idx_nxt   = '0;
              state_nxt = (count_r == '0) ? S_PR_EMP : S_PR_RD;
            end
            REQ_REVERSE: begin
              lo_nxt    = '0;
              hi_nxt    = count_r;
              pass_nxt  = PASS_TAIL;
              state_nxt = S_RV_CHK;
            end
            REQ_ROT_L, REQ_ROT_R: begin
              if (count_r != '0) begin
                mag_nxt   = in_shift[DataW-1] ? (~in_shift + 1'b1) : in_shift;
                neg_nxt   = in_shift[DataW-1] ^ (in_req == REQ_ROT_L);
                rem_nxt   = '0;
                bit_nxt   = '0;
                state_nxt = S_DIV;
              end
            end
            default: ;
          endcase
        end
      end

      // shift elements up one place, then drop the value in
      S_INS: begin
        if (idx_r > pos_r) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(idx_r - 1'b1);
          state_nxt = S_INS_WR;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = pos_r[AW-1:0];
          ram_wdata = val_r;
          count_nxt = count_r + 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_INS_WR: begin
        ram_we    = 1'b1;
        idx_nxt   = idx_r - 1'b1;
        state_nxt = S_INS;
      end

      S_MV_CAP: begin
        val_nxt   = ram_rdata;
        state_nxt = S_REM;
      end

      // shift elements down one place over the removed slot
      S_REM: begin
        if (idx_r + 1'b1 < count_r) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(idx_r + 1'b1);
          state_nxt = S_REM_WR;
        end else begin
          count_nxt = count_r - 1'b1;
          if (mv_r) begin
            idx_nxt   = count_r - 1'b1;
            pos_nxt   = (XW'(pb_r) > XW'(count_r - 1'b1)) ? (count_r - 1'b1) : CW'(pb_r);
            state_nxt = S_INS;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_REM_WR: begin
        ram_we    = 1'b1;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_REM;
      end

      // restoring remainder, one dividend bit per cycle
      S_DIV: begin
        if (bit_r == 5'd31) begin
          rem_nxt = rem_step;
          bit_nxt = '0;
          state_nxt = S_RV_CHK;
          lo_nxt    = '0;
          hi_nxt    = count_r;
          pass_nxt  = PASS_ALL;
        end else begin
          rem_nxt = rem_step;
          mag_nxt = {mag_r[DataW-2:0], 1'b0};
          bit_nxt = bit_r + 1'b1;
        end
      end

      // reverse [lo, hi); rotation runs three passes
      S_RV_CHK: begin
        if (lo_r + 1'b1 < hi_r) begin
          ram_re    = 1'b1;
          ram_raddr = lo_r[AW-1:0];
          state_nxt = S_RV_RDB;
        end else begin
          case (pass_r)
            PASS_ALL: begin
              lo_nxt   = '0;
              hi_nxt   = k_calc;
              k_nxt    = k_calc;
              pass_nxt = PASS_HEAD;
            end
            PASS_HEAD: begin
              lo_nxt   = k_r;
              hi_nxt   = count_r;
              pass_nxt = PASS_TAIL;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_RV_RDB: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(hi_r - 1'b1);
        val_nxt   = ram_rdata;
        state_nxt = S_RV_WA;
      end
      S_RV_WA: begin
        ram_we    = 1'b1;
        ram_waddr = lo_r[AW-1:0];
        state_nxt = S_RV_WB;
      end
      S_RV_WB: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(hi_r - 1'b1);
        ram_wdata = val_r;
        lo_nxt    = lo_r + 1'b1;
        hi_nxt    = hi_r - 1'b1;
        state_nxt = S_RV_CHK;
      end

      // print: one read, then one result transfer per element
      S_PR_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_PR_LD;
      end
      S_PR_LD: begin
        if (out_free) begin
          ovld_nxt   = 1'b1;
          odata_nxt  = ram_rdata;
          oempty_nxt = 1'b0;
          olast_nxt  = (idx_r + 1'b1 == count_r);
          idx_nxt    = idx_r + 1'b1;
          state_nxt  = (idx_r + 1'b1 == count_r) ? S_IDLE : S_PR_RD;
        end
      end
      S_PR_EMP: begin
        if (out_free) begin
          ovld_nxt   = 1'b1;
          odata_nxt  = '0;
          oempty_nxt = 1'b1;
          olast_nxt  = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    pb_r     <= pb_nxt;
    mv_r     <= mv_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    pass_r   <= pass_nxt;
    k_r      <= k_nxt;
    mag_r    <= mag_nxt;
    rem_r    <= rem_nxt;
    bit_r    <= bit_nxt;
    neg_r    <= neg_nxt;
    odata_r  <= odata_nxt;
    olast_r  <= olast_nxt;
    oempty_r <= oempty_nxt;
  end

endmodule

// ===== sim/ple_checker.sv =====
// Result checker for the positional list engine: mirrors the list contents
// from accepted requests and compares every print transfer. Depends on ple_pkg.
`timescale 1ns / 1ps
module ple_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [ple_pkg::InPadW-1:0]  in_tdata,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [ple_pkg::DataW-1:0]   out_tdata,
  input  logic                        out_tlast,
  input  logic                        out_tuser,
  output int                          fail_count,
  output int                          pending_prints
);
  import ple_pkg::*;

  localparam int Cap = 32;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
    logic        empty;
  } print_beat_t;

  logic [31:0] mirror_list[Cap];
  int          mirror_len;
  print_beat_t print_queue[$];

  assign pending_prints = print_queue.size();

  // insert with the position clamped to the end
  function automatic void put_elem(int pos, logic [31:0] v);
    if (pos > mirror_len) pos = mirror_len;
    for (int i = mirror_len; i > pos; i--) mirror_list[i] = mirror_list[i-1];
    mirror_list[pos] = v;
    mirror_len++;
  endfunction

  function automatic logic [31:0] take_elem(int pos);
    logic [31:0] v;
    v = mirror_list[pos];
    for (int i = pos; i + 1 < mirror_len; i++) mirror_list[i] = mirror_list[i+1];
    mirror_len--;
    return v;
  endfunction

  // element i goes to (i + amt) mod length
  function automatic void turn_right(longint amt);
    logic [31:0] tmp[Cap];
    longint r;
    if (mirror_len == 0) return;
    r = amt % mirror_len;
    if (r < 0) r += mirror_len;
    for (int i = 0; i < mirror_len; i++) tmp[(i + r) % mirror_len] = mirror_list[i];
    for (int i = 0; i < mirror_len; i++) mirror_list[i] = tmp[i];
  endfunction

  function automatic void apply_request(logic [InPadW-1:0] d);
    req_t        op;
    logic [31:0] val, t;
    int          pa, pb;
    longint      sh;
    op  = req_t'(d[2:0]);
    val = d[34:3];
    pa  = d[40:35];
    pb  = d[46:41];
    sh  = longint'($signed(d[78:47]));
    case (op)
      REQ_INSERT: if (mirror_len < Cap) put_elem(pa, val);
      REQ_REMOVE: if (pa < mirror_len) void'(take_elem(pa));
      REQ_PRINT: begin
        if (mirror_len == 0) print_queue.push_back('{32'd0, 1'b1, 1'b1});
        else for (int i = 0; i < mirror_len; i++)
          print_queue.push_back('{mirror_list[i], i + 1 == mirror_len, 1'b0});
      end
      REQ_MOVE: begin
        if (pa != pb && pa < mirror_len) begin
          t = take_elem(pa);
          put_elem(pb, t);
        end
      end
      REQ_REVERSE: begin
        for (int i = 0; i < mirror_len / 2; i++) begin
          t = mirror_list[i];
          mirror_list[i] = mirror_list[mirror_len-1-i];
          mirror_list[mirror_len-1-i] = t;
        end
      end
      REQ_ROT_L: turn_right(-sh);
      REQ_ROT_R: turn_right(sh);
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    print_beat_t want;
    if (!rst_n) begin
      mirror_len = 0;
      fail_count <= 0;
      print_queue.delete();
    end else begin
      if (in_tvalid && in_tready) apply_request(in_tdata);
      if (out_tvalid && out_tready) begin
        if (print_queue.size() == 0) begin
          $display("%0t: unexpected transfer data=%h last=%b empty=%b",
                   $time, out_tdata, out_tlast, out_tuser);
          fail_count <= fail_count + 1;
        end else begin
          want = print_queue.pop_front();
          if (want.value !== out_tdata || want.last !== out_tlast ||
              want.empty !== out_tuser) begin
            $display("%0t: mismatch expected data=%h last=%b empty=%b, got data=%h last=%b empty=%b",
                     $time, want.value, want.last, want.empty,
                     out_tdata, out_tlast, out_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== sim/tb_positional_list_engine_unit.sv =====
// Testbench top for the positional list engine: clock, reset, request stimulus
// with random idling, and the verdict. Depends on ple_pkg, the RTL and ple_checker.
`timescale 1ns / 1ps
module tb_positional_list_engine_unit;
  import ple_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [InPadW-1:0] in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DataW-1:0]  out_tdata;
  logic              out_tlast;
  logic              out_tuser;
  int                fail_count;
  int                pending_prints;
  int                send_idle_pct = 19;
  int                recv_idle_pct = 70;
  int                hold_cycles = 0;
  int                hold_requests = 0;
  int                hold_seen = 0;
  int                list_len_guess = 0;

  always #5 clk = ~clk;

  positional_list_engine_unit uut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast, .out_tuser
  );

  ple_checker chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast, .out_tuser,
    .fail_count, .pending_prints
  );

  // receiver: random stall, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen   <= hold_requests;
      hold_cycles <= 400;
      out_tready  <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // valid stays high after a transfer until the next request or an idle gap
  task automatic send_request(req_t op, logic [31:0] val, logic [5:0] pa,
                              logic [5:0] pb, logic [31:0] sh);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata  <= {1'b0, sh, pb, pa, val, op};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    if (op == REQ_INSERT && list_len_guess < 32) list_len_guess++;
    if (op == REQ_REMOVE && pa < list_len_guess) list_len_guess--;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_prints != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_shift();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom();
      default: return $urandom_range(70) - 35;
    endcase
  endfunction

  task automatic random_request();
    int   k;
    req_t op;
    k = $urandom_range(99);
    if (k < 30 + (list_len_guess < 8 ? 20 : 0)) op = REQ_INSERT;
    else if (k < 48) op = REQ_REMOVE;
    else if (k < 62) op = REQ_PRINT;
    else if (k < 74) op = REQ_MOVE;
    else if (k < 80) op = REQ_REVERSE;
    else if (k < 89) op = REQ_ROT_L;
    else if (k < 98) op = REQ_ROT_R;
    else op = REQ_NONE;
    send_request(op, $urandom(),
                 ($urandom_range(9) == 0) ? 6'($urandom()) : 6'($urandom_range(list_len_guess)),
                 ($urandom_range(9) == 0) ? 6'($urandom()) : 6'($urandom_range(list_len_guess)),
                 pick_shift());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // directed: empty list corner cases, then small-list inserts, moves and rotations
    send_request(REQ_PRINT, 0, 0, 0, 0);
    send_request(REQ_REMOVE, 0, 0, 0, 0);
    send_request(REQ_ROT_R, 0, 0, 0, 5);
    send_request(REQ_MOVE, 0, 0, 1, 0);
    send_request(REQ_INSERT, 32'h8000_0000, 0, 0, 0);
    send_request(REQ_INSERT, 32'h7fff_ffff, 63, 0, 0);
    send_request(REQ_INSERT, 32'hffff_ffff, 1, 0, 0);
    send_request(REQ_INSERT, 32'h0, 0, 0, 0);
    send_request(REQ_PRINT, 0, 0, 0, 0);
    send_request(REQ_MOVE, 0, 0, 63, 0);
    send_request(REQ_MOVE, 0, 1, 1, 0);
    send_request(REQ_MOVE, 0, 40, 0, 0);
    send_request(REQ_REVERSE, 0, 0, 0, 0);
    send_request(REQ_ROT_L, 0, 0, 0, 32'h8000_0000);
    send_request(REQ_ROT_R, 0, 0, 0, 32'h7fff_ffff);
    send_request(REQ_ROT_R, 0, 0, 0, 32'hffff_fffd);
    send_request(REQ_NONE, 32'hffff_ffff, 63, 63, 32'hffff_ffff);
    send_request(REQ_PRINT, 0, 0, 0, 0);
    send_request(REQ_REMOVE, 0, 63, 0, 0);
    send_request(REQ_REMOVE, 0, 3, 0, 0);
    // fill past capacity so the full-store insert is exercised
    for (int i = 0; i < 32; i++) send_request(REQ_INSERT, $urandom(), 6'($urandom()), 0, 0);
    // long receiver hold-off while prints back up the input
    hold_requests++;
    for (int i = 0; i < 3; i++) send_request(REQ_PRINT, 0, 0, 0, 0);
    send_request(REQ_REVERSE, 0, 0, 0, 0);
    send_request(REQ_PRINT, 0, 0, 0, 0);
    // sender pauses until every result is in
    wait_drained();
    for (int i = 0; i < 40; i++) random_request();
    send_idle_pct = 70;
    recv_idle_pct = 19;
    for (int i = 0; i < 40; i++) random_request();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 40; i++) random_request();
    send_request(REQ_PRINT, 0, 0, 0, 0);
    wait_drained();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_prints == 0)
      $display("positional_list_engine_unit regression: pass");
    else
      $display("positional_list_engine_unit regression: fail");
    $finish;
  end

  initial begin
    #5ms;
    $display("positional_list_engine_unit regression: fail");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/ple_pkg.sv
rtl/ple_ram.sv
rtl/positional_list_engine_unit.sv
sim/ple_checker.sv
sim/tb_positional_list_engine_unit.sv
